>>> rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Check that a trigger is followed in the next cycle by a consequence.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/pnghp_pkg.sv
package pnghp_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned HeightWidth = 32;
   localparam int unsigned CrcWidth    = 32;
   localparam int unsigned PosWidth    = 6;

   localparam logic [CrcWidth-1:0] CrcPoly    = 32'hEDB8_8320;
   localparam logic [CrcWidth-1:0] CrcAllOnes = 32'hFFFF_FFFF;

   localparam logic [PosWidth-1:0] CrcFirst    = 6'd12;
   localparam logic [PosWidth-1:0] CrcLength   = 6'd17;
   localparam logic [PosWidth-1:0] HeightFirst = 6'd20;
   localparam logic [PosWidth-1:0] CrcOutFirst = CrcFirst + CrcLength;
   localparam logic [PosWidth-1:0] PosLimit    = CrcOutFirst + 6'd4;

   localparam logic [HeightWidth-1:0] HeightReset = '0;

   typedef struct packed {
      logic [ByteWidth-1:0] out_byte;
      logic                 was_replaced;
   } result_type;

   // Reflected CRC-32, one byte, LSB first.
   function automatic logic [CrcWidth-1:0] crc_byte(input logic [CrcWidth-1:0] crc,
                                                    input logic [ByteWidth-1:0] data);
      logic [CrcWidth-1:0] c;
      c = crc ^ {{(CrcWidth-ByteWidth){1'b0}}, data};
      for (int b = 0; b < ByteWidth; b++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

   // Byte of a word, index 0 being the most significant byte.
   function automatic logic [ByteWidth-1:0] word_byte(input logic [31:0] word,
                                                      input logic [1:0]  idx);
      logic [ByteWidth-1:0] b;
      unique case (idx)
         2'd0: b = word[31:24];
         2'd1: b = word[23:16];
         2'd2: b = word[15:8];
         default: b = word[7:0];
      endcase
      return b;
   endfunction

endpackage

>>> rtl/pnghp_patch.sv
`include "assert_macros.svh"

module pnghp_patch (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [pnghp_pkg::HeightWidth-1:0]    csr_height,
   input  logic                                 accept,
   input  logic [pnghp_pkg::ByteWidth-1:0]      in_byte,
   input  logic                                 start_of_file,
   output pnghp_pkg::result_type                result
);

   logic [pnghp_pkg::HeightWidth-1:0] height_ff;
   logic [pnghp_pkg::PosWidth-1:0]    pos_ff, pos_in;
   logic [pnghp_pkg::CrcWidth-1:0]    crc_ff, crc_in;

   logic [pnghp_pkg::PosWidth-1:0]    pos;
   logic [pnghp_pkg::CrcWidth-1:0]    crc_base;
   logic [1:0]                        height_off, crc_off;
   logic                              in_height, in_crc_out, in_crc_span;
   logic [pnghp_pkg::CrcWidth-1:0]    crc_final;

   always_comb begin
      pos         = start_of_file ? '0 : pos_ff;
      crc_base    = start_of_file ? pnghp_pkg::CrcAllOnes : crc_ff;
      height_off  = 2'(pos - pnghp_pkg::HeightFirst);
      crc_off     = 2'(pos - pnghp_pkg::CrcOutFirst);
      in_height   = (pos >= pnghp_pkg::HeightFirst) &&
                    (pos < pnghp_pkg::HeightFirst + 6'd4);
      in_crc_out  = (pos >= pnghp_pkg::CrcOutFirst) && (pos < pnghp_pkg::PosLimit);
      in_crc_span = (pos >= pnghp_pkg::CrcFirst) && (pos < pnghp_pkg::CrcOutFirst);
      crc_final   = crc_base ^ pnghp_pkg::CrcAllOnes;

      priority if (in_height) begin
         result.out_byte     = pnghp_pkg::word_byte(height_ff, height_off);
         result.was_replaced = 1'b1;
      end else if (in_crc_out) begin
         result.out_byte     = pnghp_pkg::word_byte(crc_final, crc_off);
         result.was_replaced = 1'b1;
      end else begin
         result.out_byte     = in_byte;
         result.was_replaced = 1'b0;
      end

      // advance the CRC over the emitted (patched) byte
      crc_in = in_crc_span ? pnghp_pkg::crc_byte(crc_base, result.out_byte) : crc_base;
      pos_in = (pos < pnghp_pkg::PosLimit) ? pos + 6'd1 : pos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= pnghp_pkg::HeightReset;
         pos_ff    <= '0;
         crc_ff    <= pnghp_pkg::CrcAllOnes;
      end else begin
         if (csr_write) begin
            height_ff <= csr_height;
         end
         if (accept) begin
            pos_ff <= pos_in;
            crc_ff <= crc_in;
         end
      end
   end

   `ASSERT_ALWAYS(a_pos_saturates, clock, reset, pos_ff <= pnghp_pkg::PosLimit)
   `ASSERT_NEXT(a_start_restarts, clock, reset, accept && start_of_file, pos_ff == 6'd1)
   `ASSERT_NEXT(a_pos_advances, clock, reset,
                accept && !start_of_file && pos_ff < pnghp_pkg::PosLimit,
                pos_ff == 6'($past(pos_ff) + 6'd1))

endmodule

>>> rtl/pnghp_out_reg.sv
module pnghp_out_reg (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  pnghp_pkg::result_type             result,
   output logic                              can_load,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pnghp_pkg::ByteWidth-1:0]   rsp_tdata,
   output logic                              rsp_tuser
);

   logic                  valid_ff;
   pnghp_pkg::result_type data_ff;

   // take a new beat when empty or when the held one leaves this cycle
   assign can_load   = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff.out_byte;
   assign rsp_tuser  = data_ff.was_replaced;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (can_load) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

endmodule

>>> rtl/png_header_height_patcher_core.sv
// An accepted byte is captured in the result register, which drives rsp_.
// Throughput: one byte per cycle unless the output stalls; the per-byte CRC network and byte muxes are combinational.
// Input is stalled only while the result register holds a beat that rsp_tready refuses.
// Reset (synchronous, active high): position 0, CRC all ones, height 0, no result pending.
module png_header_height_patcher_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pnghp_pkg::ByteWidth-1:0]   req_tdata,   // [7:0] in_byte
   input  logic                              req_tuser,   // [0] start_of_file
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pnghp_pkg::ByteWidth-1:0]   rsp_tdata,   // [7:0] out_byte
   output logic                              rsp_tuser,   // [0] was_replaced
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pnghp_pkg::HeightWidth-1:0] csr_data     // [31:0] new_height
);

   logic                  accept;
   logic                  can_load;
   pnghp_pkg::result_type result;

   assign csr_ready  = 1'b1;
   assign req_tready = can_load;
   assign accept     = req_tvalid && can_load;

   pnghp_patch u_patch (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_valid && csr_ready),
      .csr_height    (csr_data),
      .accept        (accept),
      .in_byte       (req_tdata),
      .start_of_file (req_tuser),
      .result        (result)
   );

   pnghp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .result     (result),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
